// File: design/tlst_pkg.sv
`default_nettype none
package tlst_pkg;

  localparam int unsigned SlotsDef = 64;
  localparam logic [62:0] TickMax = {63{1'b1}};

  localparam logic [1:0] ModeBegin = 2'd0;
  localparam logic [1:0] ModeEnd   = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;
  localparam logic [1:0] ModeClear = 2'd3;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatFull    = 2'd1;
  localparam logic [1:0] StatUnknown = 2'd2;
  localparam logic [1:0] StatEmpty   = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] tag_key;
    logic [62:0] timestamp;
    logic [5:0]  slot_index;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] tag_out;
    logic [62:0] elapsed;
    logic [62:0] total_ticks;
    logic [62:0] min_ticks;
    logic [62:0] max_ticks;
    logic [62:0] calls;
    logic [6:0]  entries_used;
  } out_t;

  typedef struct packed {
    logic [62:0] start;
    logic [62:0] sum;
    logic [62:0] low;
    logic [62:0] high;
    logic [62:0] calls;
  } stat_row_t;

endpackage
`default_nettype wire

// File: design/tlst_fifo.sv
`default_nettype none
module tlst_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// File: design/tlst_engine.sv
`default_nettype none
module tlst_engine #(
  parameter int unsigned SLOTS = tlst_pkg::SlotsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_empty_i,
  input  wire tlst_pkg::in_t  in_word_i,
  output logic                in_pop_o,
  input  wire logic           out_full_i,
  output logic                out_push_o,
  output tlst_pkg::out_t      out_word_o
);

  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned IW = $clog2(SLOTS);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SStat = 2'd2;
  localparam logic [1:0] SUpd  = 2'd3;

  function automatic logic [5:0] slot6(input logic [IW-1:0] i);
    logic [IW+5:0] t;
    t = {6'd0, i};
    return t[5:0];
  endfunction

  logic [1:0]         state_q, state_d;
  tlst_pkg::in_t      item_q, item_d, cur;
  logic [CW-1:0]      used_q, used_d;
  logic [IW-1:0]      scan_q, scan_d;
  logic [62:0]        el_q, el_d;

  logic [31:0]        key_mem [SLOTS];
  tlst_pkg::stat_row_t stat_mem [SLOTS];
  logic [31:0]        key_rd_q;
  tlst_pkg::stat_row_t stat_rd_q, stat_wdata;
  logic               key_re, key_we, stat_re, stat_we;
  logic [IW-1:0]      key_raddr, stat_raddr, waddr;

  logic [IW+5:0]      idx_ext;
  logic [IW-1:0]      idx_iw;
  logic [CW+5:0]      idx_cmp, used_cmp;
  logic [CW+6:0]      used_ext;
  logic               hit, miss, at_end;
  logic [63:0]        sum_wide;

  assign cur      = (state_q == SIdle) ? in_word_i : item_q;
  assign idx_ext  = {{IW{1'b0}}, cur.slot_index};
  assign idx_iw   = idx_ext[IW-1:0];
  assign idx_cmp  = {{CW{1'b0}}, cur.slot_index};
  assign used_cmp = {6'd0, used_q};
  assign hit      = key_rd_q == item_q.tag_key;
  assign at_end   = (CW'(scan_q) + CW'(1)) == used_q;
  assign sum_wide = {1'b0, stat_rd_q.sum} + {1'b0, el_q};

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    used_d     = used_q;
    scan_d     = scan_q;
    el_d       = el_q;
    in_pop_o   = 1'b0;
    out_push_o = 1'b0;
    key_re     = 1'b0;
    key_we     = 1'b0;
    stat_re    = 1'b0;
    stat_we    = 1'b0;
    key_raddr  = '0;
    stat_raddr = '0;
    waddr      = scan_q;
    stat_wdata = stat_rd_q;
    miss       = 1'b0;
    out_word_o = '0;

    case (state_q)
      SIdle: begin
        if (!in_empty_i && !out_full_i) begin
          in_pop_o = 1'b1;
          item_d   = in_word_i;
          case (in_word_i.mode)
            tlst_pkg::ModeClear: begin
              used_d     = '0;
              out_push_o = 1'b1;
            end
            tlst_pkg::ModeRead: begin
              if (idx_cmp < used_cmp) begin
                key_re     = 1'b1;
                stat_re    = 1'b1;
                key_raddr  = idx_iw;
                stat_raddr = idx_iw;
                state_d    = SStat;
              end else begin
                out_push_o        = 1'b1;
                out_word_o.status = tlst_pkg::StatEmpty;
                out_word_o.slot   = in_word_i.slot_index;
              end
            end
            default: begin
              if (used_q == '0) begin
                miss = 1'b1;
              end else begin
                key_re  = 1'b1;
                scan_d  = '0;
                state_d = SScan;
              end
            end
          endcase
        end
      end
      SScan: begin
        if (hit) begin
          stat_re    = 1'b1;
          stat_raddr = scan_q;
          state_d    = SStat;
        end else if (at_end) begin
          miss    = 1'b1;
          state_d = SIdle;
        end else begin
          scan_d    = scan_q + IW'(1);
          key_re    = 1'b1;
          key_raddr = scan_q + IW'(1);
        end
      end
      SStat: begin
        out_word_o.total_ticks = stat_rd_q.sum;
        out_word_o.min_ticks   = stat_rd_q.low;
        out_word_o.max_ticks   = stat_rd_q.high;
        out_word_o.calls       = stat_rd_q.calls;
        case (item_q.mode)
          tlst_pkg::ModeRead: begin
            out_push_o         = 1'b1;
            out_word_o.slot    = item_q.slot_index;
            out_word_o.tag_out = key_rd_q;
            state_d            = SIdle;
          end
          tlst_pkg::ModeBegin: begin
            stat_we            = 1'b1;
            stat_wdata.start   = item_q.timestamp;
            out_push_o         = 1'b1;
            out_word_o.slot    = slot6(scan_q);
            out_word_o.tag_out = item_q.tag_key;
            state_d            = SIdle;
          end
          default: begin
            el_d    = (item_q.timestamp >= stat_rd_q.start) ?
                      item_q.timestamp - stat_rd_q.start : '0;
            state_d = SUpd;
          end
        endcase
      end
      SUpd: begin
        stat_we          = 1'b1;
        stat_wdata.sum   = sum_wide[63] ? tlst_pkg::TickMax : sum_wide[62:0];
        stat_wdata.low   = (el_q < stat_rd_q.low) ? el_q : stat_rd_q.low;
        stat_wdata.high  = (el_q > stat_rd_q.high) ? el_q : stat_rd_q.high;
        stat_wdata.calls = (stat_rd_q.calls == tlst_pkg::TickMax) ?
                           stat_rd_q.calls : stat_rd_q.calls + 63'd1;
        out_push_o             = 1'b1;
        out_word_o.slot        = slot6(scan_q);
        out_word_o.tag_out     = item_q.tag_key;
        out_word_o.elapsed     = el_q;
        out_word_o.total_ticks = stat_wdata.sum;
        out_word_o.min_ticks   = stat_wdata.low;
        out_word_o.max_ticks   = stat_wdata.high;
        out_word_o.calls       = stat_wdata.calls;
        state_d                = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    // key not in table: allocate on begin (or report a full table), flag on end
    if (miss) begin
      out_push_o = 1'b1;
      if (cur.mode == tlst_pkg::ModeEnd) begin
        out_word_o.status = tlst_pkg::StatUnknown;
      end else if (used_q == CW'(SLOTS)) begin
        out_word_o.status = tlst_pkg::StatFull;
      end else begin
        waddr              = used_q[IW-1:0];
        key_we             = 1'b1;
        stat_we            = 1'b1;
        stat_wdata.start   = cur.timestamp;
        stat_wdata.sum     = '0;
        stat_wdata.low     = tlst_pkg::TickMax;
        stat_wdata.high    = '0;
        stat_wdata.calls   = '0;
        used_d             = used_q + CW'(1);
        out_word_o.slot    = slot6(used_q[IW-1:0]);
        out_word_o.tag_out = cur.tag_key;
        out_word_o.min_ticks = tlst_pkg::TickMax;
      end
    end

    used_ext = {7'd0, used_d};
    out_word_o.entries_used = used_ext[6:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    scan_q <= scan_d;
    el_q   <= el_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[waddr] <= cur.tag_key;
    end
    if (key_re) begin
      key_rd_q <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_we) begin
      stat_mem[waddr] <= stat_wdata;
    end
    if (stat_re) begin
      stat_rd_q <= stat_mem[stat_raddr];
    end
  end

  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_pop_o |-> !out_full_i) else $error("item taken without result room");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |=> state_q == SIdle) else $error("engine busy after result");
  a_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(SLOTS)) else $error("entry count beyond table size");
  a_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SScan |-> CW'(scan_q) < used_q) else $error("scan past last entry");

endmodule
`default_nettype wire

// File: design/tagged_latency_stats_table.sv
// Latency statistics table, queue-style ports on both sides. Begin and end
// words look up their tag by walking the key memory one entry per cycle;
// a found tag then has its statistics row read, and end words pass an update
// state too. New or unknown tags are answered at the end of the walk, or at
// once on an empty table. Read words read the slot's rows first; table-clear
// words and reads of an empty slot are answered straight away. Table memories
// need no clearing pass after reset. Up to two words are buffered on each side.
`default_nettype none
module tagged_latency_stats_table #(
  parameter int unsigned SLOTS = tlst_pkg::SlotsDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  input  wire tlst_pkg::in_t  in_word_i,
  output logic                full,
  input  wire logic           pop,
  output tlst_pkg::out_t      out_word_o,
  output logic                empty
);

  tlst_pkg::in_t  q_word;
  tlst_pkg::out_t res_word;
  logic           q_empty, q_pop, res_full, res_push;

  tlst_fifo #(.Width($bits(tlst_pkg::in_t))) u_inq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (in_word_i),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o (q_word),
    .empty_o (q_empty)
  );

  tlst_engine #(.SLOTS(SLOTS)) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_empty_i (q_empty),
    .in_word_i  (q_word),
    .in_pop_o   (q_pop),
    .out_full_i (res_full),
    .out_push_o (res_push),
    .out_word_o (res_word)
  );

  tlst_fifo #(.Width($bits(tlst_pkg::out_t))) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_word_o),
    .empty_o (empty)
  );

endmodule
`default_nettype wire

// File: sim/tagged_latency_stats_table_tb.sv
`default_nettype none
module tagged_latency_stats_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  tlst_pkg::in_t in_word_i = '0;
  tlst_pkg::out_t out_word_o;
  logic full, empty;

  tagged_latency_stats_table #(.SLOTS(Slots)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .in_word_i(in_word_i),
    .full(full), .pop(pop), .out_word_o(out_word_o), .empty(empty)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] key_mem [Slots];
  logic [62:0] start_mem [Slots];
  logic [62:0] sum_mem [Slots];
  logic [62:0] low_mem [Slots];
  logic [62:0] high_mem [Slots];
  logic [62:0] calls_mem [Slots];
  int unsigned used_n = 0;

  tlst_pkg::in_t pending_words[$];
  tlst_pkg::out_t expected_words[$];
  int unsigned err_count = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit stim_done = 0;
  bit in_taken = 0;
  logic [31:0] live_keys[$];

  function automatic tlst_pkg::out_t entry_stats(int unsigned i);
    tlst_pkg::out_t r;
    r = '0;
    r.slot = i[5:0];
    r.tag_out = key_mem[i];
    r.total_ticks = sum_mem[i];
    r.min_ticks = low_mem[i];
    r.max_ticks = high_mem[i];
    r.calls = calls_mem[i];
    return r;
  endfunction

  function automatic tlst_pkg::out_t predict_stats(tlst_pkg::in_t w);
    tlst_pkg::out_t r;
    int found;
    logic [62:0] el;
    logic [63:0] s;
    r = '0;
    found = -1;
    if (w.mode == tlst_pkg::ModeBegin || w.mode == tlst_pkg::ModeEnd)
      for (int i = 0; i < used_n; i++)
        if (found < 0 && key_mem[i] == w.tag_key) found = i;
    case (w.mode)
      tlst_pkg::ModeBegin: begin
        if (found >= 0) begin
          start_mem[found] = w.timestamp;
          r = entry_stats(found);
        end else if (used_n < Slots) begin
          key_mem[used_n] = w.tag_key;
          start_mem[used_n] = w.timestamp;
          sum_mem[used_n] = '0;
          low_mem[used_n] = tlst_pkg::TickMax;
          high_mem[used_n] = '0;
          calls_mem[used_n] = '0;
          r = entry_stats(used_n);
          used_n++;
        end else begin
          r.status = tlst_pkg::StatFull;
        end
      end
      tlst_pkg::ModeEnd: begin
        if (found >= 0) begin
          el = (w.timestamp >= start_mem[found]) ? w.timestamp - start_mem[found] : '0;
          s = {1'b0, sum_mem[found]} + {1'b0, el};
          sum_mem[found] = (s > {1'b0, tlst_pkg::TickMax}) ? tlst_pkg::TickMax : s[62:0];
          if (el < low_mem[found]) low_mem[found] = el;
          if (el > high_mem[found]) high_mem[found] = el;
          if (calls_mem[found] != tlst_pkg::TickMax) calls_mem[found]++;
          r = entry_stats(found);
          r.elapsed = el;
        end else begin
          r.status = tlst_pkg::StatUnknown;
        end
      end
      tlst_pkg::ModeRead: begin
        if (w.slot_index < used_n) begin
          r = entry_stats(w.slot_index);
        end else begin
          r.status = tlst_pkg::StatEmpty;
          r.slot = w.slot_index;
        end
      end
      default: used_n = 0;
    endcase
    r.entries_used = used_n[6:0];
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        expected_words.push_back(predict_stats(in_word_i));
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_word_i <= pending_words[0];
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    in_taken = rst_ni && push && !full;
    if (rst_ni && pop && !empty) begin
      if (expected_words.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected word %h", out_word_o);
      end else begin
        if (out_word_o !== expected_words[0]) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp %h got %h", expected_words[0], out_word_o);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  function automatic logic [62:0] rand_ts();
    logic [62:0] t;
    case ($urandom_range(3))
      0: t = '0;
      1: t = tlst_pkg::TickMax - 63'($urandom_range(3));
      2: t = 63'($urandom_range(1000));
      default: t = 63'({$urandom, $urandom});
    endcase
    return t;
  endfunction

  function automatic tlst_pkg::in_t make_word(logic [1:0] m, logic [31:0] k,
                                              logic [62:0] t, logic [5:0] s);
    tlst_pkg::in_t w;
    w.mode = m;
    w.tag_key = k;
    w.timestamp = t;
    w.slot_index = s;
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || push || expected_words.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic random_burst(int unsigned n);
    tlst_pkg::in_t w;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      w = make_word(2'($urandom_range(2)), $urandom, rand_ts(), 6'($urandom));
      if ($urandom_range(9) < 7 && live_keys.size() > 0)
        k = live_keys[$urandom_range(live_keys.size() - 1)];
      else begin
        k = ($urandom_range(1)) ? $urandom : 32'($urandom_range(40));
        if (live_keys.size() < 80) live_keys.push_back(k);
      end
      w.tag_key = k;
      // a begin is followed by a matching end about half of the time
      if (w.mode == tlst_pkg::ModeBegin && $urandom_range(1)) begin
        pending_words.push_back(w);
        w.mode = tlst_pkg::ModeEnd;
        w.timestamp = w.timestamp + 63'($urandom_range(500));
      end
      if ($urandom_range(60) == 0) begin
        w.mode = tlst_pkg::ModeClear;
        live_keys.delete();
      end
      pending_words.push_back(w);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed
    pending_words.push_back(make_word(tlst_pkg::ModeRead, '0, '0, 6'd0));
    pending_words.push_back(make_word(tlst_pkg::ModeEnd, 32'hFFFF_FFFF,
                                      tlst_pkg::TickMax, 6'd63));
    pending_words.push_back(make_word(tlst_pkg::ModeBegin, 32'hFFFF_FFFF, '0, 6'd63));
    pending_words.push_back(make_word(tlst_pkg::ModeEnd, 32'hFFFF_FFFF,
                                      tlst_pkg::TickMax, '0));
    pending_words.push_back(make_word(tlst_pkg::ModeBegin, 32'hFFFF_FFFF,
                                      tlst_pkg::TickMax, '0));
    pending_words.push_back(make_word(tlst_pkg::ModeEnd, 32'hFFFF_FFFF,
                                      tlst_pkg::TickMax, '0));
    pending_words.push_back(make_word(tlst_pkg::ModeBegin, '0, tlst_pkg::TickMax, '0));
    pending_words.push_back(make_word(tlst_pkg::ModeEnd, '0, 63'd5, '0)); // went backwards
    pending_words.push_back(make_word(tlst_pkg::ModeRead, '0, '0, 6'd1));
    pending_words.push_back(make_word(tlst_pkg::ModeRead, '0, '0, 6'd2));
    pending_words.push_back(make_word(tlst_pkg::ModeRead, '0, '0, 6'd63));
    pending_words.push_back(make_word(tlst_pkg::ModeClear, 32'hFFFF_FFFF,
                                      tlst_pkg::TickMax, 6'd63));
    pending_words.push_back(make_word(tlst_pkg::ModeRead, '0, '0, 6'd0));
    // fill the table, then overflow it
    for (int i = 0; i < Slots + 2; i++)
      pending_words.push_back(make_word(tlst_pkg::ModeBegin, 32'(i * 7 + 1), 63'(i), '0));
    pending_words.push_back(make_word(tlst_pkg::ModeEnd, 32'd1, 63'd100, '0));
    pending_words.push_back(make_word(tlst_pkg::ModeRead, '0, '0, 6'd63));
    pending_words.push_back(make_word(tlst_pkg::ModeClear, '0, '0, '0));
    send_idle = 8;
    recv_idle = 88;
    wait_drained();
    random_burst(280);
    wait_drained();
    send_idle = 88;
    recv_idle = 8;
    random_burst(280);
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    random_burst(290);
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
